// ===== rtl/core/cmpr_pkg.sv =====
// Shared types and constants for the CAN multi-frame packet reassembler.
// Holds the result record, status and file-action codes, and register indexes.
// No dependencies; imported by cmpr_out_reg, the top level and the testbench.
`default_nettype none

package cmpr_pkg;

  // Identifier match and frame numbering.
  localparam logic [31:0] ID_MASK      = 32'hffffff00;
  localparam logic [7:0]  FN_START     = 8'h01;
  localparam logic [7:0]  FN_MID_LO    = 8'h02;
  localparam logic [7:0]  FN_MID_HI    = 8'h0c;
  localparam logic [7:0]  FN_LAST      = 8'hff;

  // Header bytes that open the first frame of a packet.
  localparam logic [7:0]  HDR_BYTE0    = 8'h1b;
  localparam logic [7:0]  HDR_BYTE1    = 8'h01;

  // Longest packet that fits in sixteen output words.
  localparam logic [7:0]  MAX_PKT_LEN  = 8'd128;

  // Configuration reset values.
  localparam logic [31:0] MATCH_ID_RST = 32'h19fff000;
  localparam logic [7:0]  PKT_LEN_RST  = 8'd98;
  localparam logic [7:0]  FILE_LIM_RST = 8'd130;

  typedef enum logic [1:0] {
    REG_MATCH_ID   = 2'd0,
    REG_PKT_LEN    = 2'd1,
    REG_FILE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OTHER_ID   = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_FRAME  = 3'd2,
    ST_APPENDED   = 3'd3,
    ST_LEN_ERROR  = 3'd4,
    ST_COMPLETE   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_START   = 2'd1,
    ACT_APPEND  = 2'd2,
    ACT_TOO_BIG = 2'd3
  } action_t;

  // One result record as handed to the output register.
  typedef struct packed {
    logic        accepted;
    status_t     status;
    action_t     file_action;
    logic [7:0]  packet_index;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmpr_buffer.sv =====
// Packet buffer: one synchronous memory of 8-byte rows with byte-lane write
// enables and a registered read port. No package use.
`default_nettype none

module cmpr_buffer #(
  parameter int ROWS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    wr_en,
  input  wire logic [$clog2(ROWS)-1:0] wr_row,
  input  wire logic [7:0]              wr_be,
  input  wire logic [63:0]             wr_data,
  input  wire logic                    rd_en,
  input  wire logic [$clog2(ROWS)-1:0] rd_row,
  output logic      [63:0]             rd_data
);

  logic [63:0] mem [ROWS];

  // Byte-lane write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int l = 0; l < 8; l++) begin
        if (wr_be[l]) begin
          mem[wr_row][8*l +: 8] <= wr_data[8*l +: 8];
        end
      end
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cmpr_out_reg.sv =====
// Output register for result records: decouples the sequencer from the
// master stream and packs the record into tdata. Uses cmpr_pkg.
`default_nettype none

module cmpr_out_reg
  import cmpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push_valid,
  input  res_t             push_res,
  output logic             push_ready,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0 up: accepted, status, file_action, packet_index,
  // out_word, out_bytes, zero fill
  output logic [87:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  logic held_valid;
  res_t held;

  // The register takes a new record when it is empty or being drained.
  assign push_ready = !held_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (push_ready) begin
      held_valid <= push_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      held <= push_res;
    end
  end

  // Stream side.
  assign m_axis_tvalid = held_valid;
  assign m_axis_tlast  = held.last;
  assign m_axis_tdata  = {6'd0, held.out_bytes, held.out_word, held.packet_index,
                          held.file_action, held.status, held.accepted};

endmodule

`default_nettype wire

// ===== rtl/core/can_multiframe_packet_reassembler.sv =====
// Top level of the CAN multi-frame packet reassembler: configuration
// registers, frame sequencer, and instances of cmpr_buffer and cmpr_out_reg.
// Uses cmpr_pkg.
//
//   port group   dir  payload                                  handshake
//   s_axis       in   can_id[31:0], frame_data[95:32]           tvalid/tready
//   m_axis       out  result record, tlast = last               tvalid/tready
//   cfg          in   cfg_addr register index, cfg_wdata         cfg_we
//
// A frame that only appends passes through decode, the buffer write states WR_LO and WR_HI
// (a frame's bytes may span two 8-byte rows) and a result push. A completing frame
// replaces the push with a check state and, for each of up to sixteen output words, a
// read issue (the memory read is registered) and then a push. Output stalls hold the
// sequencer at its push states; one frame is in work at a time. Reset clears the count
// and flags only; the buffer has no clearing pass because bytes are read only below
// the byte count.
`default_nettype none

module can_multiframe_packet_reassembler
  import cmpr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata from bit 0 up: can_id, frame_data
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata from bit 0 up: accepted, status, file_action, packet_index,
  // out_word, out_bytes, zero fill
  output logic [87:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int ROWS = (BUFFER_DEPTH + 7) / 8;
  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int LW   = (CW > 8) ? CW : 8;

  typedef enum logic [2:0] {
    IDLE, DECODE, WR_LO, WR_HI, CHECK, RD_ISSUE, RD_WAIT, RESP
  } state_t;

  state_t      state;
  logic [31:0] match_id;
  logic [7:0]  pkt_len;
  logic [7:0]  file_limit;

  logic [31:0] frm_id;
  logic [63:0] frm_data;
  logic [63:0] payload;
  logic [3:0]  n_push;
  logic        is_last_frame;
  logic [CW-1:0] cnt;
  logic        ovf;
  logic        res_acc;
  status_t     res_status;
  logic [3:0]  k;
  logic [7:0]  idx_q;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_id   <= MATCH_ID_RST;
      pkt_len    <= PKT_LEN_RST;
      file_limit <= FILE_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_MATCH_ID:   match_id   <= cfg_wdata;
        REG_PKT_LEN:    pkt_len    <= cfg_wdata[7:0];
        REG_FILE_LIMIT: file_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Frame decode from the captured frame.
  logic [7:0] fn;
  logic       id_match;
  logic       hdr_ok;
  assign fn       = frm_id[7:0];
  assign id_match = (frm_id & ID_MASK) == (match_id & ID_MASK);
  assign hdr_ok   = (frm_data[7:0] == HDR_BYTE0) && (frm_data[15:8] == HDR_BYTE1);

  // Placement of the pending bytes: byte i lands at address cnt + i, which is
  // lane (cnt + i) mod 8 of the current row or of the next one.
  logic [CW-1:0] avail;
  logic [CW-1:0] stored;
  logic [2:0]    off;
  logic [7:0]    be_lo;
  logic [7:0]    be_hi;
  logic [63:0]   rot_data;
  logic [RW-1:0] row_lo;
  logic [RW-1:0] row_hi;

  assign avail    = CW'(BUFFER_DEPTH) - cnt;
  assign stored   = (CW'(n_push) > avail) ? avail : CW'(n_push);
  assign off      = cnt[2:0];
  assign row_lo   = cnt[RW+2:3];
  assign row_hi   = row_lo + RW'(1);
  assign rot_data = (payload << {off, 3'b000}) | (payload >> (7'd64 - {1'b0, off, 3'b000}));

  always_comb begin
    logic [3:0] pos;
    logic       take;
    be_lo = '0;
    be_hi = '0;
    for (int i = 0; i < 8; i++) begin
      pos  = {1'b0, off} + 4'(i);
      take = (4'(i) < n_push) && (CW'(i) < avail);
      if (pos[3]) begin
        be_hi[pos[2:0]] = take;
      end else begin
        be_lo[pos[2:0]] = take;
      end
    end
  end

  // Completion check.
  logic len_err;
  assign len_err = ovf || (LW'(cnt) != LW'(pkt_len)) || (pkt_len == 8'd0) ||
                   (pkt_len > MAX_PKT_LEN);

  // Word assembly during read-out.
  logic [63:0] rd_data;
  logic [8:0]  len_p7;
  logic [4:0]  nwords;
  logic [7:0]  rem;
  logic [3:0]  nbytes;
  logic [63:0] word_masked;
  logic [7:0]  idx_cur;
  action_t     action;
  logic        word_last;

  assign len_p7    = {1'b0, pkt_len} + 9'd7;
  assign nwords    = len_p7[7:3] | {len_p7[8], 4'd0};
  assign rem       = pkt_len - {1'b0, k, 3'b000};
  assign nbytes    = (rem >= 8'd8) ? 4'd8 : rem[3:0];
  assign idx_cur   = (k == 4'd0) ? rd_data[7:0] : idx_q;
  assign word_last = ({1'b0, k} + 5'd1) == nwords;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      word_masked[8*j +: 8] = (4'(j) < nbytes) ? rd_data[8*j +: 8] : 8'd0;
    end
  end

  always_comb begin
    if (idx_cur == 8'd0) begin
      action = ACT_START;
    end else if (idx_cur < file_limit) begin
      action = ACT_APPEND;
    end else begin
      action = ACT_TOO_BIG;
    end
  end

  // Result record toward the output register.
  logic push_valid;
  logic push_ready;
  res_t push_res;

  always_comb begin
    push_valid = 1'b0;
    push_res   = '{accepted: res_acc, status: res_status, file_action: ACT_NONE,
                   packet_index: 8'd0, out_word: 64'd0, out_bytes: 4'd0, last: 1'b1};
    if (state == RESP) begin
      push_valid = 1'b1;
    end else if (state == RD_WAIT) begin
      push_valid = 1'b1;
      push_res   = '{accepted: 1'b1, status: ST_COMPLETE, file_action: action,
                     packet_index: idx_cur, out_word: word_masked,
                     out_bytes: nbytes, last: word_last};
    end
  end

  // Buffer port control.
  logic          buf_we;
  logic [RW-1:0] buf_wrow;
  logic [7:0]    buf_be;
  logic          buf_re;
  logic [RW-1:0] buf_rrow;

  assign buf_be   = (state == WR_HI) ? be_hi : be_lo;
  assign buf_wrow = (state == WR_HI) ? row_hi : row_lo;
  assign buf_we   = ((state == WR_LO) || (state == WR_HI)) && (|buf_be);
  assign buf_re   = (state == RD_ISSUE);
  assign buf_rrow = RW'(k);

  assign s_axis_tready = (state == IDLE);

  // Sequencer. Writes and reads of the buffer sit in separate states, so no
  // read can overlap a pending write to the same row.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            frm_id   <= s_axis_tdata[31:0];
            frm_data <= s_axis_tdata[95:32];
            state    <= DECODE;
          end
        end
        DECODE: begin
          if (!id_match) begin
            res_acc    <= 1'b0;
            res_status <= ST_OTHER_ID;
            state      <= RESP;
          end else if (fn == FN_START) begin
            if (!hdr_ok) begin
              res_acc    <= 1'b0;
              res_status <= ST_BAD_HEADER;
              state      <= RESP;
            end else begin
              // A valid first frame restarts the packet.
              cnt           <= '0;
              ovf           <= 1'b0;
              payload       <= {16'd0, frm_data[63:16]};
              n_push        <= 4'd6;
              is_last_frame <= 1'b0;
              res_acc       <= 1'b1;
              res_status    <= ST_APPENDED;
              state         <= WR_LO;
            end
          end else if ((fn >= FN_MID_LO) && (fn <= FN_MID_HI)) begin
            payload       <= frm_data;
            n_push        <= 4'd8;
            is_last_frame <= 1'b0;
            res_acc       <= 1'b1;
            res_status    <= ST_APPENDED;
            state         <= WR_LO;
          end else if (fn == FN_LAST) begin
            payload       <= frm_data;
            n_push        <= 4'd4;
            is_last_frame <= 1'b1;
            state         <= WR_LO;
          end else begin
            res_acc    <= 1'b0;
            res_status <= ST_BAD_FRAME;
            state      <= RESP;
          end
        end
        WR_LO: begin
          state <= WR_HI;
        end
        WR_HI: begin
          cnt <= cnt + stored;
          if (CW'(n_push) > avail) begin
            ovf <= 1'b1;
          end
          state <= is_last_frame ? CHECK : RESP;
        end
        CHECK: begin
          if (len_err) begin
            res_acc    <= 1'b0;
            res_status <= ST_LEN_ERROR;
            state      <= RESP;
          end else begin
            k     <= 4'd0;
            state <= RD_ISSUE;
          end
        end
        RD_ISSUE: begin
          state <= RD_WAIT;
        end
        RD_WAIT: begin
          if (push_ready) begin
            if (k == 4'd0) begin
              idx_q <= rd_data[7:0];
            end
            if (word_last) begin
              state <= IDLE;
            end else begin
              k     <= k + 4'd1;
              state <= RD_ISSUE;
            end
          end
        end
        RESP: begin
          if (push_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  cmpr_buffer #(
    .ROWS (ROWS)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_row  (buf_wrow),
    .wr_be   (buf_be),
    .wr_data (rot_data),
    .rd_en   (buf_re),
    .rd_row  (buf_rrow),
    .rd_data (rd_data)
  );

  cmpr_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .push_valid    (push_valid),
    .push_res      (push_res),
    .push_ready    (push_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The byte count never passes the buffer size.
  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(BUFFER_DEPTH))
    else $error("byte count beyond buffer depth");

  // Overflow is only flagged once the buffer is completely full.
  assert property (@(posedge clk) disable iff (rst) ovf |-> (cnt == CW'(BUFFER_DEPTH)))
    else $error("overflow flag set with room left in buffer");

  // The buffer is never written and read in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(buf_we && buf_re))
    else $error("buffer write and read overlap");

  // Once a frame is taken, no other frame is taken in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
                   (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second frame taken while decoding");

endmodule

`default_nettype wire

// ===== tb/cmpr_checker.sv =====
// Result checker for the CAN multi-frame packet reassembler testbench.
// Watches the register-write, frame and result channels, predicts every result
// transaction and compares it field by field. Depends on cmpr_pkg only.
`default_nettype none

module cmpr_checker
  import cmpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [87:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  output int               error_count,
  output int               outstanding,
  output int               results_seen,
  output int               packets_done
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_DEPTH = 128;

  // Shadow of the reassembly state and the configuration registers.
  logic [7:0]  pkt_buf [BUF_DEPTH];
  int          byte_cnt;
  bit          overflow;
  logic [31:0] match_reg;
  logic [7:0]  length_reg;
  logic [7:0]  limit_reg;

  // Results predicted but not yet seen on the output channel, oldest first.
  res_t        expected_words [$];

  function automatic res_t single_result(bit acc, status_t st);
    res_t r;
    r = '0;
    r.accepted = acc;
    r.status   = st;
    r.last     = 1'b1;
    return r;
  endfunction

  // Bytes past the buffer end are dropped and mark the packet as overflowed.
  function automatic void store_byte(logic [7:0] b);
    if (byte_cnt < BUF_DEPTH) begin
      pkt_buf[byte_cnt] = b;
      byte_cnt++;
    end else begin
      overflow = 1'b1;
    end
  endfunction

  // Updates the shadow state for one frame and queues the results it causes.
  function automatic void reassemble_frame(logic [31:0] id, logic [63:0] data);
    logic [7:0] fn;
    logic [7:0] idx;
    action_t    act;
    res_t       r;
    int         len;
    int         nwords;
    int         n;
    fn = id[7:0];
    if ((id & ID_MASK) != (match_reg & ID_MASK)) begin
      expected_words.push_back(single_result(1'b0, ST_OTHER_ID));
    end else if (fn == FN_START) begin
      if (data[7:0] != HDR_BYTE0 || data[15:8] != HDR_BYTE1) begin
        expected_words.push_back(single_result(1'b0, ST_BAD_HEADER));
      end else begin
        byte_cnt = 0;
        overflow = 1'b0;
        for (int i = 2; i < 8; i++) store_byte(data[8*i +: 8]);
        expected_words.push_back(single_result(1'b1, ST_APPENDED));
      end
    end else if (fn >= FN_MID_LO && fn <= FN_MID_HI) begin
      for (int i = 0; i < 8; i++) store_byte(data[8*i +: 8]);
      expected_words.push_back(single_result(1'b1, ST_APPENDED));
    end else if (fn != FN_LAST) begin
      expected_words.push_back(single_result(1'b0, ST_BAD_FRAME));
    end else begin
      // Closing frame: append four bytes, then check the total length.
      for (int i = 0; i < 4; i++) store_byte(data[8*i +: 8]);
      len = int'(length_reg);
      if (overflow || byte_cnt != len || len == 0 || len > int'(MAX_PKT_LEN)) begin
        expected_words.push_back(single_result(1'b0, ST_LEN_ERROR));
      end else begin
        idx = pkt_buf[0];
        if (idx == 8'd0) act = ACT_START;
        else if (idx < limit_reg) act = ACT_APPEND;
        else act = ACT_TOO_BIG;
        nwords = (len + 7) / 8;
        for (int k = 0; k < nwords; k++) begin
          n = (len - 8*k > 8) ? 8 : len - 8*k;
          r = '0;
          r.accepted     = 1'b1;
          r.status       = ST_COMPLETE;
          r.file_action  = act;
          r.packet_index = idx;
          for (int j = 0; j < n; j++) r.out_word[8*j +: 8] = pkt_buf[8*k + j];
          r.out_bytes    = 4'(n);
          r.last         = (k == nwords - 1);
          expected_words.push_back(r);
        end
        packets_done++;
      end
    end
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      error_count++;
    end
  endfunction

  // Register writes, frame transactions and result transactions, in that order.
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      byte_cnt   = 0;
      overflow   = 1'b0;
      match_reg  = MATCH_ID_RST;
      length_reg = PKT_LEN_RST;
      limit_reg  = FILE_LIM_RST;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MATCH_ID:   match_reg = cfg_wdata;
          REG_PKT_LEN:    length_reg = cfg_wdata[7:0];
          REG_FILE_LIMIT: limit_reg = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        reassemble_frame(s_axis_tdata[31:0], s_axis_tdata[95:32]);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          $error("result transaction arrived with no result expected");
          error_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("accepted", want.accepted, m_axis_tdata[0]);
          compare_field("status", want.status, m_axis_tdata[3:1]);
          compare_field("file_action", want.file_action, m_axis_tdata[5:4]);
          compare_field("packet_index", want.packet_index, m_axis_tdata[13:6]);
          compare_field("out_word", want.out_word, m_axis_tdata[77:14]);
          compare_field("out_bytes", want.out_bytes, m_axis_tdata[81:78]);
          compare_field("last", want.last, m_axis_tlast);
        end
      end
    end
    outstanding <= expected_words.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Top of the CAN multi-frame packet reassembler testbench: clock, reset,
// register writes, frame stimulus and receiver stalls, plus the verdict.
// Depends on cmpr_pkg, can_multiframe_packet_reassembler and cmpr_checker.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cmpr_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_MATCH_ID;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tlast;

  int error_count;
  int outstanding;
  int results_seen;
  int packets_done;

  // Idle and stall odds in percent, and the register values now in force.
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [31:0] cur_match = MATCH_ID_RST;
  logic [7:0]  cur_length = PKT_LEN_RST;
  logic [7:0]  cur_limit = FILE_LIM_RST;
  int          frames_sent = 0;
  int          setting_cnt = 0;

  always #5 clk = ~clk;

  can_multiframe_packet_reassembler u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  cmpr_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .error_count   (error_count),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .packets_done  (packets_done)
  );

  // Receiver side: random back-pressure at the current stall rate.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [31:0] own_id(logic [7:0] fn);
    return {cur_match[31:8], fn};
  endfunction

  function automatic logic [63:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // Packet index biased toward zero and both sides of the append limit.
  function automatic logic [7:0] pick_index();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return cur_limit - 8'd1;
      2: return cur_limit;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] header_data(logic [7:0] index);
    logic [63:0] d;
    d = rand_data();
    d[7:0]   = HDR_BYTE0;
    d[15:8]  = HDR_BYTE1;
    d[23:16] = index;
    return d;
  endfunction

  // One frame transaction, preceded by random idle cycles.
  task automatic send_frame(input logic [31:0] id, input logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (id[31:8] == cur_match[31:8]) frames_sent++;
  endtask

  // Stops sending and waits until every predicted result has been seen.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Writes all three registers once the block is idle.
  task automatic set_config(input logic [31:0] m, input logic [7:0] l, input logic [7:0] f);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_MATCH_ID;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_addr  <= REG_PKT_LEN;
    cfg_wdata <= {24'd0, l};
    @(posedge clk);
    cfg_addr  <= REG_FILE_LIMIT;
    cfg_wdata <= {24'd0, f};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_match  = m;
    cur_length = l;
    cur_limit  = f;
    setting_cnt++;
  endtask

  // Frames that change nothing: foreign ids, bad headers, bad frame numbers.
  task automatic send_noise();
    logic [63:0] d;
    logic [7:0]  fn;
    case ($urandom_range(3))
      0: send_frame($urandom, rand_data());
      1: begin
        fn = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(254, 13));
        send_frame(own_id(fn), rand_data());
      end
      2: begin
        d = header_data(pick_index());
        case ($urandom_range(2))
          0: d[7:0] = d[7:0] ^ (8'd1 << $urandom_range(7));
          1: d[15:8] = d[15:8] ^ (8'd1 << $urandom_range(7));
          default: d[15:0] = 16'($urandom);
        endcase
        send_frame(own_id(FN_START), d);
      end
      default: send_frame(own_id(8'($urandom)) ^ (32'd256 << $urandom_range(23)),
                          rand_data());
    endcase
  endtask

  // Optional start, middle and closing frames in random order with noise, final close if ends > 0.
  task automatic send_packet(input int mids, input int ends, input bit with_start,
                             input int noise_pct);
    int left_mid;
    int left_end;
    left_mid = mids;
    left_end = ends - 1;
    if (with_start) send_frame(own_id(FN_START), header_data(pick_index()));
    while (left_mid + left_end > 0) begin
      if ($urandom_range(99) < noise_pct) begin
        send_noise();
      end else if ($urandom_range(left_mid + left_end - 1) < left_mid) begin
        send_frame(own_id(8'($urandom_range(12, 2))), rand_data());
        left_mid--;
      end else begin
        send_frame(own_id(FN_LAST), rand_data());
        left_end--;
      end
    end
    if (ends > 0) send_frame(own_id(FN_LAST), rand_data());
  endtask

  // Splits the length into middle frames and closing frames so that it matches.
  task automatic send_good_packet();
    int rem;
    int extra;
    rem = int'(cur_length) - 10;
    extra = (rem % 8 == 4) ? 1 : 0;
    if (rem - 4*extra >= 8 && $urandom_range(3) == 0) extra += 2;
    send_packet((rem - 4*extra) / 8, extra + 1, 1'b1, 10);
  endtask

  initial begin
    int target;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: frames that are ignored or rejected under the reset settings.
    send_frame(32'hffffffff, 64'hffffffffffffffff);
    send_frame(own_id(FN_START), 64'h0);
    send_frame(own_id(8'd0), rand_data());
    send_frame(own_id(8'd13), rand_data());
    send_frame(own_id(8'd254), rand_data());

    // Directed: fill the buffer to exactly its depth without a start frame;
    // the first close is short by four bytes, the second emits sixteen words.
    set_config(32'h19fff0ff, 8'd128, 8'hff);
    for (int i = 0; i < 15; i++)
      send_frame(own_id(FN_MID_LO + 8'(i % 11)), i[0] ? 64'hffffffffffffffff : 64'h0);
    send_frame(own_id(FN_LAST), 64'hffffffffffffffff);
    send_frame(own_id(FN_LAST), rand_data());

    // Directed: shortest complete packet, as file start and as index too big.
    set_config(32'h0, 8'd10, 8'd0);
    send_frame(own_id(FN_START), header_data(8'd0));
    send_frame(own_id(FN_LAST), rand_data());
    send_frame(own_id(FN_START), header_data(8'd5));
    send_frame(own_id(FN_LAST), rand_data());

    // Random phases, each with its own settings and idle mix.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      case (p)
        0: set_config(32'hffffffff, 8'(10 + 4*$urandom_range(28)), 8'hff);
        1: set_config($urandom, 8'd128, 8'($urandom));
        2: set_config(32'h0, 8'(10 + 4*$urandom_range(28)), 8'd0);
        3: set_config($urandom, 8'd1, 8'($urandom));
        default: set_config($urandom, 8'(10 + 4*$urandom_range(28)), 8'($urandom));
      endcase
      target = frames_sent + 48;
      while (frames_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 70 && cur_length >= 8'd10 && cur_length[1:0] == 2'd2) begin
          send_good_packet();
        end else if (pick < 88) begin
          send_packet($urandom_range(16), $urandom_range(3, 1), $urandom_range(4) != 0, 20);
        end else begin
          repeat ($urandom_range(3, 1)) send_noise();
        end
      end
    end

    // Let the last results drain, then watch for stray output.
    drain_results();
    repeat (40) @(posedge clk);
    $display("Run covered %0d frames under %0d register settings, with idle and stall mixes.",
             frames_sent, setting_cnt);
    $display("%0d result transactions checked, %0d packets reassembled.",
             results_seen, packets_done);
    if (error_count == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/cmpr_pkg.sv
rtl/core/cmpr_buffer.sv
rtl/core/cmpr_out_reg.sv
rtl/core/can_multiframe_packet_reassembler.sv
tb/cmpr_checker.sv
tb/tb.sv
